// ===== rtl/core/asmp_pkg.sv =====
// Shared types and constants for the slab maximum-projection block.
// Depends on nothing; the front end, the back end and the top module import it.
`timescale 1ns / 1ps

package asmp_pkg;

  // Configuration register indexes (byte address = 4 * index).
  localparam logic [2:0] REG_VOL_WIDTH  = 3'd0;
  localparam logic [2:0] REG_VOL_HEIGHT = 3'd1;
  localparam logic [2:0] REG_VOL_DEPTH  = 3'd2;
  localparam logic [2:0] REG_AXIS_SEL   = 3'd3;
  localparam logic [2:0] REG_SLAB_START = 3'd4;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam int WIDTH_CW  = 9;
  localparam int HEIGHT_CW = 9;
  localparam int DEPTH_CW  = 11;
  localparam int AXIS_CW   = 2;
  localparam int SLAB_CW   = 9;

  localparam logic [WIDTH_CW-1:0]  WIDTH_RST  = 9'd256;
  localparam logic [HEIGHT_CW-1:0] HEIGHT_RST = 9'd256;
  localparam logic [DEPTH_CW-1:0]  DEPTH_RST  = 11'd1;
  localparam logic [SLAB_CW-1:0]   SLAB_RST   = 9'd0;

  // AXIS_NONE counts voxels but projects nothing.
  typedef enum logic [AXIS_CW-1:0] {
    AXIS_X    = 2'd0,
    AXIS_Y    = 2'd1,
    AXIS_Z    = 2'd2,
    AXIS_NONE = 2'd3
  } axis_t;

  // One configuration write as seen by the front end.
  typedef struct packed {
    logic              en;
    logic [2:0]        idx;
    logic [PDATA_W-1:0] data;
  } cfg_wr_t;

  // A classified voxel travelling from the front end to the back end.
  typedef struct packed {
    logic signed [15:0] value;
    logic [7:0]         u;
    logic [9:0]         v;
    logic               first;
    logic               fin;
    logic               last;
  } item_t;

endpackage

// ===== rtl/core/asmp_fifo.sv =====
// Small synchronous first-in first-out queue built from registers.
// Depends on nothing; used between the front and back ends and on the result side.
`timescale 1ns / 1ps

module asmp_fifo #(
  parameter int DW    = 8,
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic [DW-1:0] rdata,
  output logic          empty
);

  localparam int PW = $clog2(DEPTH);

  logic [DW-1:0] mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]   count_r, count_nxt;
  logic          wr_en, rd_en;

  assign full  = (count_r == (PW+1)'(DEPTH));
  assign empty = (count_r == '0);
  assign wr_en = push && !full;
  assign rd_en = pop && !empty;
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_en ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = rd_en ? rd_ptr_r + PW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en && !rd_en) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (PW+1)'(DEPTH))
    else $error("fifo count exceeds depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    PW'(wr_ptr_r - rd_ptr_r) == count_r[PW-1:0])
    else $error("fifo pointers disagree with count");

  a_push_fills: assert property (@(posedge clk) disable iff (!rst_n)
    empty && push |=> !empty)
    else $error("fifo stayed empty after a push");
`endif

endmodule

// ===== rtl/core/asmp_front.sv =====
// Front end: configuration registers, voxel position tracking and slab classification.
// Depends on asmp_pkg; feeds the back end through a queue.
`timescale 1ns / 1ps

module asmp_front #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_DEPTH  = 1024,
  localparam int IW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  asmp_pkg::cfg_wr_t   cfg_wr,
  input  logic [2:0]          cfg_rd_idx,
  output logic [31:0]         cfg_rdata,
  input  logic                in_push,
  input  logic signed [15:0]  in_value,
  input  logic                q_full,
  output logic                q_push,
  output asmp_pkg::item_t     q_item,
  output logic [IW-1:0]       q_idx
);
  import asmp_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int ZW = $clog2(MAX_DEPTH);
  localparam int WCW = $clog2(MAX_WIDTH + 1);
  localparam int HCW = $clog2(MAX_HEIGHT + 1);
  localparam int DCW = $clog2(MAX_DEPTH + 1);
  localparam int MAXWH = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int MAXALL = (MAXWH > MAX_DEPTH) ? MAXWH : MAX_DEPTH;
  localparam int AW = $clog2(MAXALL);
  localparam int LW = $clog2(MAXALL + 1);

  logic [WIDTH_CW-1:0]  w_cfg_r;
  logic [HEIGHT_CW-1:0] h_cfg_r;
  logic [DEPTH_CW-1:0]  d_cfg_r;
  logic [AXIS_CW-1:0]   axis_r;
  logic [SLAB_CW-1:0]   slab_r;

  logic [XW-1:0] x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;
  logic [ZW-1:0] z_r, z_nxt;
  logic [IW-1:0] pix_r, pix_nxt;

  logic [WCW-1:0] w_eff;
  logic [HCW-1:0] h_eff;
  logic [DCW-1:0] d_eff;
  logic           x_last, y_last, z_last;
  logic           accept;

  logic [LW-1:0]  len_c, s_max, s_c, e_c, a_ext;
  logic [AW-1:0]  a_c;
  logic [IW-1:0]  idx_c;
  logic [7:0]     u_c;
  logic [9:0]     v_c;
  logic           last_c, axis_ok, in_slab;

  // Sizes of zero act as one; oversize values saturate at the build maximum.
  assign w_eff = (w_cfg_r == '0) ? WCW'(1) :
                 (32'(w_cfg_r) > 32'(MAX_WIDTH)) ? WCW'(MAX_WIDTH) : WCW'(w_cfg_r);
  assign h_eff = (h_cfg_r == '0) ? HCW'(1) :
                 (32'(h_cfg_r) > 32'(MAX_HEIGHT)) ? HCW'(MAX_HEIGHT) : HCW'(h_cfg_r);
  assign d_eff = (d_cfg_r == '0) ? DCW'(1) :
                 (32'(d_cfg_r) > 32'(MAX_DEPTH)) ? DCW'(MAX_DEPTH) : DCW'(d_cfg_r);

  assign x_last = (32'(x_r) == 32'(w_eff) - 32'd1);
  assign y_last = (32'(y_r) == 32'(h_eff) - 32'd1);
  assign z_last = (32'(z_r) == 32'(d_eff) - 32'd1);

  assign accept = in_push && !q_full;

  always_comb begin
    len_c   = LW'(1);
    a_c     = '0;
    idx_c   = '0;
    u_c     = '0;
    v_c     = '0;
    last_c  = 1'b0;
    axis_ok = 1'b1;
    case (axis_t'(axis_r))
      AXIS_X: begin
        len_c  = LW'(w_eff);
        a_c    = AW'(x_r);
        u_c    = 8'(y_r);
        v_c    = 10'(z_r);
        last_c = y_last && z_last;
      end
      AXIS_Y: begin
        len_c  = LW'(h_eff);
        a_c    = AW'(y_r);
        idx_c  = IW'(x_r);
        u_c    = 8'(x_r);
        v_c    = 10'(z_r);
        last_c = x_last && z_last;
      end
      AXIS_Z: begin
        len_c  = LW'(d_eff);
        a_c    = AW'(z_r);
        idx_c  = pix_r;
        u_c    = 8'(x_r);
        v_c    = 10'(y_r);
        last_c = x_last && y_last;
      end
      default: begin
        axis_ok = 1'b0;
      end
    endcase
  end

  // The slab start is held to the middle of the axis so the slab is never empty.
  assign s_max   = (len_c - LW'(1)) >> 1;
  assign s_c     = (32'(slab_r) > 32'(s_max)) ? s_max : LW'(slab_r);
  assign e_c     = len_c - LW'(1) - s_c;
  assign a_ext   = LW'(a_c);
  assign in_slab = (a_ext >= s_c) && (a_ext <= e_c);

  assign q_push       = accept && axis_ok && in_slab;
  assign q_idx        = idx_c;
  assign q_item.value = in_value;
  assign q_item.u     = u_c;
  assign q_item.v     = v_c;
  assign q_item.first = (a_ext == s_c);
  assign q_item.fin   = (a_ext == e_c);
  assign q_item.last  = last_c;

  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    z_nxt   = z_r;
    pix_nxt = pix_r;
    if (cfg_wr.en) begin
      x_nxt   = '0;
      y_nxt   = '0;
      z_nxt   = '0;
      pix_nxt = '0;
    end else if (accept) begin
      x_nxt   = x_last ? '0 : x_r + XW'(1);
      pix_nxt = (x_last && y_last) ? '0 : pix_r + IW'(1);
      if (x_last) begin
        y_nxt = y_last ? '0 : y_r + YW'(1);
        if (y_last) begin
          z_nxt = z_last ? '0 : z_r + ZW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r   <= '0;
      y_r   <= '0;
      z_r   <= '0;
      pix_r <= '0;
    end else begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      pix_r <= pix_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_cfg_r <= WIDTH_RST;
      h_cfg_r <= HEIGHT_RST;
      d_cfg_r <= DEPTH_RST;
      axis_r  <= AXIS_Z;
      slab_r  <= SLAB_RST;
    end else if (cfg_wr.en) begin
      case (cfg_wr.idx)
        REG_VOL_WIDTH:  w_cfg_r <= cfg_wr.data[WIDTH_CW-1:0];
        REG_VOL_HEIGHT: h_cfg_r <= cfg_wr.data[HEIGHT_CW-1:0];
        REG_VOL_DEPTH:  d_cfg_r <= cfg_wr.data[DEPTH_CW-1:0];
        REG_AXIS_SEL:   axis_r  <= cfg_wr.data[AXIS_CW-1:0];
        REG_SLAB_START: slab_r  <= cfg_wr.data[SLAB_CW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_rd_idx)
      REG_VOL_WIDTH:  cfg_rdata = 32'(w_cfg_r);
      REG_VOL_HEIGHT: cfg_rdata = 32'(h_cfg_r);
      REG_VOL_DEPTH:  cfg_rdata = 32'(d_cfg_r);
      REG_AXIS_SEL:   cfg_rdata = 32'(axis_r);
      REG_SLAB_START: cfg_rdata = 32'(slab_r);
      default:        cfg_rdata = '0;
    endcase
  end

`ifndef SYNTHESIS
  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(x_r) < 32'(w_eff)) && (32'(y_r) < 32'(h_eff)) && (32'(z_r) < 32'(d_eff)))
    else $error("voxel position outside the configured volume");

  a_pix_matches: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pix_r) == 32'(y_r) * 32'(w_eff) + 32'(x_r))
    else $error("slice pixel counter out of step with position");

  a_push_valid_axis: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full && (axis_r != AXIS_NONE))
    else $error("queue push on a full queue or an unused axis");
`endif

endmodule

// ===== rtl/core/asmp_back.sv =====
// Back end: running-maximum store with read, compare and write-back per voxel.
// Depends on asmp_pkg; drains the front queue and feeds the result queue.
`timescale 1ns / 1ps

module asmp_back #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  localparam int IW = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_empty,
  input  asmp_pkg::item_t q_item,
  input  logic [IW-1:0]   q_idx,
  output logic            q_pop,
  input  logic            o_full,
  output logic            o_push,
  output asmp_pkg::item_t o_item
);
  import asmp_pkg::*;

  localparam int DEPTH = 2 ** IW;

  logic signed [15:0] store_mem [DEPTH];

  logic               s1_vld_r, s1_vld_nxt;
  item_t              s1_item_r;
  logic [IW-1:0]      s1_idx_r;
  logic signed [15:0] rdata_r;

  // Last write-back, forwarded when the next voxel hits the same pixel.
  logic               wr_vld_r;
  logic [IW-1:0]      wr_idx_r;
  logic signed [15:0] wr_val_r;

  logic signed [15:0] cur_val, new_val;
  logic               s1_go, load;

  assign cur_val = (wr_vld_r && (wr_idx_r == s1_idx_r)) ? wr_val_r : rdata_r;
  assign new_val = (s1_item_r.first || (cur_val < s1_item_r.value)) ?
                   s1_item_r.value : cur_val;

  assign s1_go = s1_vld_r && (!s1_item_r.fin || !o_full);
  assign load  = !q_empty && (!s1_vld_r || s1_go);
  assign q_pop = load;

  assign o_push       = s1_go && s1_item_r.fin;
  assign o_item.value = new_val;
  assign o_item.u     = s1_item_r.u;
  assign o_item.v     = s1_item_r.v;
  assign o_item.first = s1_item_r.first;
  assign o_item.fin   = s1_item_r.fin;
  assign o_item.last  = s1_item_r.last;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (load) begin
      s1_vld_nxt = 1'b1;
    end else if (s1_go) begin
      s1_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      wr_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      if (s1_go) begin
        wr_vld_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_item_r <= q_item;
      s1_idx_r  <= q_idx;
    end
    if (s1_go) begin
      wr_idx_r <= s1_idx_r;
      wr_val_r <= new_val;
    end
  end

  // Store port: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (s1_go) begin
      store_mem[s1_idx_r] <= new_val;
    end
    if (load) begin
      rdata_r <= store_mem[q_idx];
    end
  end

`ifndef SYNTHESIS
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_go |=> s1_vld_r && $stable(s1_idx_r) && $stable(s1_item_r))
    else $error("stalled voxel changed in the back end");

  a_max_not_below: assert property (@(posedge clk) disable iff (!rst_n)
    o_push |-> (o_item.value >= s1_item_r.value))
    else $error("emitted maximum is below the closing voxel");

  a_push_only_fin: assert property (@(posedge clk) disable iff (!rst_n)
    o_push |-> s1_vld_r && s1_item_r.fin && !o_full)
    else $error("result pushed without a closing slab voxel");
`endif

endmodule

// ===== rtl/core/axis_slab_max_projection_unit.sv =====
// Slab maximum-intensity projection: front end, queue, max-store back end, result queue.
// Depends on asmp_pkg, asmp_front, asmp_fifo and asmp_back.
// Throughput: one voxel per cycle while full is low, set by the single read and write
// port of the max store. A result goes through the back-end stage and the result queue.
// Reset (rst_n low, synchronous) clears position, queues and registers to their defaults;
// the max store is not cleared, each pixel is loaded at its slab start before use.
`timescale 1ns / 1ps

module axis_slab_max_projection_unit #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_DEPTH  = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // Voxel input channel
  input  logic                         push,
  output logic                         full,
  input  logic signed [15:0]           in_voxel_value,
  // Projection result channel
  output logic                         empty,
  input  logic                         pop,
  output logic signed [15:0]           out_proj_value,
  output logic [7:0]                   out_proj_u,
  output logic [9:0]                   out_proj_v,
  output logic                         out_last_pixel,
  // Configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [asmp_pkg::PADDR_W-1:0] paddr,
  input  logic [asmp_pkg::PDATA_W-1:0] pwdata,
  output logic [asmp_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);
  import asmp_pkg::*;

  localparam int IW    = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int QDW   = $bits(item_t) + IW;
  localparam int ODW   = $bits(item_t);

  // Register writes complete in the access phase; the port never waits.
  cfg_wr_t cfg_wr;
  assign pready      = 1'b1;
  assign cfg_wr.en   = psel && penable && pwrite && pready;
  assign cfg_wr.idx  = paddr[PADDR_W-1:2];
  assign cfg_wr.data = pwdata;

  // Front end to queue: only voxels inside the slab are queued; all others
  // just advance the position counters.
  logic          fq_push, fq_full, fq_pop, fq_empty;
  item_t         fq_item, bq_item;
  logic [IW-1:0] fq_idx, bq_idx;
  logic [QDW-1:0] fq_rdata;

  asmp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_DEPTH  (MAX_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr     (cfg_wr),
    .cfg_rd_idx (paddr[PADDR_W-1:2]),
    .cfg_rdata  (prdata),
    .in_push    (push),
    .in_value   (in_voxel_value),
    .q_full     (fq_full),
    .q_push     (fq_push),
    .q_item     (fq_item),
    .q_idx      (fq_idx)
  );

  // A full queue stalls the voxel channel directly.
  assign full = fq_full;

  asmp_fifo #(
    .DW    (QDW),
    .DEPTH (4)
  ) u_work_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fq_push),
    .wdata ({fq_item, fq_idx}),
    .full  (fq_full),
    .pop   (fq_pop),
    .rdata (fq_rdata),
    .empty (fq_empty)
  );

  assign {bq_item, bq_idx} = fq_rdata;

  // Back end: store read, compare against the voxel and write-back, with
  // forwarding of the previous write so that consecutive voxels on the same
  // pixel see each other.
  logic  oq_push, oq_full;
  item_t oq_item, oq_head;
  logic [ODW-1:0] oq_rdata;

  asmp_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_empty (fq_empty),
    .q_item  (bq_item),
    .q_idx   (bq_idx),
    .q_pop   (fq_pop),
    .o_full  (oq_full),
    .o_push  (oq_push),
    .o_item  (oq_item)
  );

  // Result queue: the back end keeps accepting voxels while earlier results
  // wait for the consumer to pop them.
  asmp_fifo #(
    .DW    (ODW),
    .DEPTH (2)
  ) u_result_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (oq_push),
    .wdata (oq_item),
    .full  (oq_full),
    .pop   (pop),
    .rdata (oq_rdata),
    .empty (empty)
  );

  assign oq_head        = oq_rdata;
  assign out_proj_value = oq_head.value;
  assign out_proj_u     = oq_head.u;
  assign out_proj_v     = oq_head.v;
  assign out_last_pixel = oq_head.last;

endmodule
